// ===== src/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
// Used by fbpa_ctrl, fbpa_datapath and fixed_block_pool_allocator; depends on nothing.
package fbpa_pkg;

  localparam int MAX_CHUNKS_DEF = 16;
  localparam int BLK_W          = 8;
  localparam int BSIZE_W        = 13;
  localparam int OFFSET_W       = 20;
  localparam int CHUNK_OUT_W    = 4;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 13;
  localparam int TAB_W          = 2 * BLK_W;

  localparam logic [BSIZE_W-1:0] BSIZE_MAX   = 13'd4096;
  localparam logic [BSIZE_W-1:0] BSIZE_RST   = 13'd16;
  localparam logic [BLK_W-1:0]   NBLOCKS_RST = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE       = 1'b0,
    REG_BLOCKS_PER_CHUNK = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_GRANT    = 2'd0,
    ST_RELEASED = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_REJECT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_INIT,
    S_ACT,
    S_POP,
    S_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_next;
    logic take_cur;
    logic take_scan;
    logic init_start;
    logic init_step;
    logic activate;
    logic pop;
    logic rel_write;
    logic res_nospace;
    logic res_reject;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic req_rel;
    logic cur_valid;
    logic cnt_zero;
    logic active_zero;
    logic rel_ok;
    logic scan_last;
    logic pool_full;
    logic init_last;
    logic out_free;
  } stat_t;

endpackage

// ===== src/fbpa_ctrl.sv =====
// Controller state machine of the fixed block pool allocator.
// Depends on fbpa_pkg; drives fbpa_datapath through fbpa_pkg::cmd_t.
module fbpa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fbpa_pkg::stat_t stat,
  output fbpa_pkg::cmd_t  cmd
);

  fbpa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbpa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fbpa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = fbpa_pkg::S_DECIDE;
      end
      fbpa_pkg::S_DECIDE: begin
        if (stat.req_rel) state_nxt = fbpa_pkg::S_EMIT;
        else if (stat.cur_valid && !stat.cnt_zero) state_nxt = fbpa_pkg::S_POP;
        else if (stat.active_zero) state_nxt = fbpa_pkg::S_INIT;
        else state_nxt = fbpa_pkg::S_SCAN;
      end
      fbpa_pkg::S_SCAN: begin
        if (!stat.cnt_zero) state_nxt = fbpa_pkg::S_POP;
        else if (stat.scan_last) begin
          state_nxt = stat.pool_full ? fbpa_pkg::S_EMIT : fbpa_pkg::S_INIT;
        end
      end
      fbpa_pkg::S_INIT: begin
        if (stat.init_last) state_nxt = fbpa_pkg::S_ACT;
      end
      fbpa_pkg::S_ACT:  state_nxt = fbpa_pkg::S_POP;
      fbpa_pkg::S_POP:  state_nxt = fbpa_pkg::S_EMIT;
      fbpa_pkg::S_EMIT: begin
        if (stat.out_free) state_nxt = fbpa_pkg::S_IDLE;
      end
      default: state_nxt = fbpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      fbpa_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      fbpa_pkg::S_DECIDE: begin
        if (stat.req_rel) begin
          cmd.rel_write  = stat.rel_ok;
          cmd.res_reject = !stat.rel_ok;
        end else if (stat.cur_valid && !stat.cnt_zero) begin
          cmd.take_cur = 1'b1;
        end else if (stat.active_zero) begin
          cmd.init_start = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
        end
      end
      fbpa_pkg::S_SCAN: begin
        if (!stat.cnt_zero) begin
          cmd.take_scan = 1'b1;
        end else if (stat.scan_last) begin
          cmd.res_nospace = stat.pool_full;
          cmd.init_start  = !stat.pool_full;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      fbpa_pkg::S_INIT: cmd.init_step = 1'b1;
      fbpa_pkg::S_ACT:  cmd.activate  = 1'b1;
      fbpa_pkg::S_POP:  cmd.pop       = 1'b1;
      fbpa_pkg::S_EMIT: cmd.load_out  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/fbpa_datapath.sv =====
// Datapath of the fixed block pool allocator: config registers, link and chunk
// table memories, pool bookkeeping and the output register. Depends on fbpa_pkg.
module fbpa_datapath #(
  parameter int MAX_CHUNKS = fbpa_pkg::MAX_CHUNKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_req_type,
  input  logic [3:0]                          in_chunk_index,
  input  logic [fbpa_pkg::BLK_W-1:0]          in_block_index,
  input  fbpa_pkg::cmd_t                      cmd,
  output fbpa_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [fbpa_pkg::CHUNK_OUT_W-1:0]    out_chunk_index_out,
  output logic [fbpa_pkg::BLK_W-1:0]          out_block_index_out,
  output logic [fbpa_pkg::OFFSET_W-1:0]       out_byte_offset
);

  localparam int CW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int AW   = $clog2(MAX_CHUNKS + 1);
  localparam int CMPW = (AW > 4) ? AW : 4;
  localparam int LAW  = CW + fbpa_pkg::BLK_W;
  localparam int BW   = fbpa_pkg::BLK_W;
  localparam int PW   = BW + fbpa_pkg::BSIZE_W;

  // config
  logic [fbpa_pkg::BSIZE_W-1:0] bsize_r;
  logic [BW-1:0]                nblk_r;
  logic [fbpa_pkg::BSIZE_W-1:0] eff_bsize;
  logic [BW-1:0]                eff_nblk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsize_r <= fbpa_pkg::BSIZE_RST;
      nblk_r  <= fbpa_pkg::NBLOCKS_RST;
    end else if (cfg_valid) begin
      case (fbpa_pkg::reg_idx_t'(cfg_index))
        fbpa_pkg::REG_BLOCK_SIZE:       bsize_r <= cfg_data;
        fbpa_pkg::REG_BLOCKS_PER_CHUNK: nblk_r  <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  assign eff_bsize = (bsize_r > fbpa_pkg::BSIZE_MAX) ? fbpa_pkg::BSIZE_MAX : bsize_r;
  assign eff_nblk  = (nblk_r == '0) ? BW'(1) : nblk_r;

  // pool bookkeeping
  logic          cur_valid_r;
  logic [CW-1:0] cur_chunk_r;
  logic [AW-1:0] active_r;
  logic [CW-1:0] scan_r;
  logic [BW-1:0] init_k_r;
  logic          req_rel_r;
  logic [3:0]    req_chunk_r;
  logic [BW-1:0] req_block_r;
  logic [CW-1:0] op_chunk_r;
  logic [BW-1:0] op_head_r;
  logic [BW-1:0] op_cnt_r;
  logic [CW-1:0] new_chunk;
  logic [CW-1:0] scan_inc;

  // memory read data: head in the upper byte, count in the lower byte
  logic [fbpa_pkg::TAB_W-1:0] tab_rd_r;
  logic [BW-1:0]              link_rd_r;
  logic [BW-1:0]              tab_head;
  logic [BW-1:0]              tab_cnt;

  assign tab_head  = tab_rd_r[fbpa_pkg::TAB_W-1:BW];
  assign tab_cnt   = tab_rd_r[BW-1:0];
  assign new_chunk = active_r[CW-1:0];
  assign scan_inc  = scan_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_chunk_r <= '0;
      active_r    <= '0;
    end else begin
      if (cmd.take_scan) begin
        cur_valid_r <= 1'b1;
        cur_chunk_r <= scan_r;
      end else if (cmd.activate) begin
        cur_valid_r <= 1'b1;
        cur_chunk_r <= new_chunk;
        active_r    <= active_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_rel_r   <= in_req_type;
      req_chunk_r <= in_chunk_index;
      req_block_r <= in_block_index;
    end
    if (cmd.scan_start) scan_r <= '0;
    else if (cmd.scan_next) scan_r <= scan_inc;
    if (cmd.init_start) init_k_r <= '0;
    else if (cmd.init_step) init_k_r <= init_k_r + BW'(1);
    if (cmd.take_cur || cmd.take_scan) begin
      op_chunk_r <= cmd.take_cur ? cur_chunk_r : scan_r;
      op_head_r  <= tab_head;
      op_cnt_r   <= tab_cnt;
    end else if (cmd.activate) begin
      op_chunk_r <= new_chunk;
      op_head_r  <= '0;
      op_cnt_r   <= eff_nblk;
    end
  end

  // chunk table: head and free count per chunk
  logic [fbpa_pkg::TAB_W-1:0] tab_mem [MAX_CHUNKS];
  logic                       tab_re;
  logic [CW-1:0]              tab_ra;
  logic                       tab_we;
  logic [CW-1:0]              tab_wa;
  logic [fbpa_pkg::TAB_W-1:0] tab_wd;

  always_comb begin
    tab_re = cmd.capture || cmd.scan_start || cmd.scan_next;
    if (cmd.capture) tab_ra = in_req_type ? CW'(in_chunk_index) : cur_chunk_r;
    else if (cmd.scan_start) tab_ra = '0;
    else tab_ra = scan_inc;
    tab_we = cmd.pop || cmd.rel_write;
    if (cmd.pop) begin
      tab_wa = op_chunk_r;
      tab_wd = {link_rd_r, op_cnt_r - BW'(1)};
    end else begin
      tab_wa = CW'(req_chunk_r);
      tab_wd = {req_block_r, tab_cnt + BW'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    if (tab_re) tab_rd_r <= tab_mem[tab_ra];
  end

  // link store: one next-free link per block
  logic [BW-1:0]  link_mem [MAX_CHUNKS * (1 << BW)];
  logic           link_re;
  logic [LAW-1:0] link_ra;
  logic           link_we;
  logic [LAW-1:0] link_wa;
  logic [BW-1:0]  link_wd;

  always_comb begin
    link_re = cmd.take_cur || cmd.take_scan || cmd.activate;
    if (cmd.take_cur) link_ra = {cur_chunk_r, tab_head};
    else if (cmd.take_scan) link_ra = {scan_r, tab_head};
    else link_ra = {new_chunk, BW'(0)};
    link_we = cmd.init_step || cmd.rel_write;
    if (cmd.init_step) begin
      link_wa = {new_chunk, init_k_r};
      link_wd = init_k_r + BW'(1);
    end else begin
      link_wa = {CW'(req_chunk_r), req_block_r};
      link_wd = tab_head;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd_r <= link_mem[link_ra];
  end

  // result staging and output register
  logic [1:0]                       res_status_r;
  logic [fbpa_pkg::CHUNK_OUT_W-1:0] res_chunk_r;
  logic [BW-1:0]                    res_block_r;
  logic [fbpa_pkg::OFFSET_W-1:0]    res_offset_r;
  logic [PW-1:0]                    offset_prod;
  logic                             out_valid_r, out_valid_nxt;

  assign offset_prod = PW'(op_head_r) * PW'(eff_bsize);

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      res_status_r <= fbpa_pkg::ST_GRANT;
      res_chunk_r  <= fbpa_pkg::CHUNK_OUT_W'(op_chunk_r);
      res_block_r  <= op_head_r;
      res_offset_r <= offset_prod[fbpa_pkg::OFFSET_W-1:0];
    end else if (cmd.rel_write || cmd.res_reject || cmd.res_nospace) begin
      if (cmd.rel_write) res_status_r <= fbpa_pkg::ST_RELEASED;
      else if (cmd.res_reject) res_status_r <= fbpa_pkg::ST_REJECT;
      else res_status_r <= fbpa_pkg::ST_NO_SPACE;
      res_chunk_r  <= '0;
      res_block_r  <= '0;
      res_offset_r <= '0;
    end
    if (cmd.load_out) begin
      out_status          <= res_status_r;
      out_chunk_index_out <= res_chunk_r;
      out_block_index_out <= res_block_r;
      out_byte_offset     <= res_offset_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // status to controller
  always_comb begin
    stat.req_rel     = req_rel_r;
    stat.cur_valid   = cur_valid_r;
    stat.cnt_zero    = (tab_cnt == '0);
    stat.active_zero = (active_r == '0);
    stat.rel_ok      = (CMPW'(req_chunk_r) < CMPW'(active_r)) && (req_block_r < eff_nblk);
    stat.scan_last   = ((AW'(scan_r) + AW'(1)) == active_r);
    stat.pool_full   = (active_r == AW'(MAX_CHUNKS));
    stat.init_last   = (init_k_r == (eff_nblk - BW'(1)));
    stat.out_free    = !out_valid_r || out_ready;
  end

endmodule

// ===== src/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator, top level: joins controller and datapath.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_datapath.
//
// The pool holds up to MAX_CHUNKS chunks of blocks_per_chunk blocks; each chunk
// keeps its free list in a link store (one 8-bit link per block) plus a head
// and free count in a chunk table, both on-chip memories with one read and one
// write port. Each request word produces exactly one result word. Steps per
// word: a release or a rejected release goes through S_IDLE, S_DECIDE and
// S_EMIT; an allocation served from the current chunk goes through S_IDLE,
// S_DECIDE, S_POP and S_EMIT; when the current chunk is empty, the chunk table
// is scanned one chunk per cycle from chunk 0; when no active chunk has space,
// activating a new chunk writes its links one block per cycle through the single
// link-store write port, then S_ACT. A pool-full answer comes after the full scan.
// The block takes one request word at a time; a new word is accepted while
// the previous result word still waits in the output register. Config words
// are accepted every cycle and must only be written while the block is idle.
// No clearing pass runs after reset: the memories start undefined and are
// written as chunks are activated.
module fixed_block_pool_allocator #(
  parameter int MAX_CHUNKS = fbpa_pkg::MAX_CHUNKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  logic [3:0]                          in_chunk_index,
  input  logic [fbpa_pkg::BLK_W-1:0]          in_block_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [fbpa_pkg::CHUNK_OUT_W-1:0]    out_chunk_index_out,
  output logic [fbpa_pkg::BLK_W-1:0]          out_block_index_out,
  output logic [fbpa_pkg::OFFSET_W-1:0]       out_byte_offset
);

  fbpa_pkg::cmd_t  cmd;
  fbpa_pkg::stat_t stat;

  // config registers take a word in any cycle
  assign cfg_ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbpa_datapath #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_req_type         (in_req_type),
    .in_chunk_index      (in_chunk_index),
    .in_block_index      (in_block_index),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_chunk_index_out (out_chunk_index_out),
    .out_block_index_out (out_block_index_out),
    .out_byte_offset     (out_byte_offset)
  );

endmodule

// ===== verif/fixed_block_pool_allocator_test.sv =====
// Self-checking bench for fixed_block_pool_allocator: drives request words, predicts each
// response word with a behavioral copy of the chunked free lists and compares field by field.
// Depends on fbpa_pkg and the fixed_block_pool_allocator RTL.
module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  localparam int POOL_CHUNKS  = MAX_CHUNKS_DEF;
  // Generous bound on the whole run: scans cover at most 16 chunks, at most 16 chunk
  // activations each write up to 255 links, and stalls are random.
  localparam int CYCLE_LIMIT  = 500000;
  // Longest single word: full scan plus link initialization of a 255-block chunk.
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_MAX   = 50;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct {
    status_t                status;
    logic [CHUNK_OUT_W-1:0] chunk;
    logic [BLK_W-1:0]       block;
    logic [OFFSET_W-1:0]    offset;
  } response_t;

  typedef struct {
    logic [3:0]       chunk;
    logic [BLK_W-1:0] block;
  } held_block_t;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  in_req_type    = 1'b0;
  logic [3:0]            in_chunk_index = '0;
  logic [BLK_W-1:0]      in_block_index = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [1:0]            out_status;
  logic [CHUNK_OUT_W-1:0] out_chunk_index_out;
  logic [BLK_W-1:0]      out_block_index_out;
  logic [OFFSET_W-1:0]   out_byte_offset;

  fixed_block_pool_allocator i_dut (.*);

  // Pool copy: per-chunk link array, free-list head and free count, plus the
  // allocation cursor and the register settings currently in force.
  logic [BLK_W-1:0]   pool_links [POOL_CHUNKS][256];
  logic [BLK_W-1:0]   pool_heads [POOL_CHUNKS];
  logic [BLK_W-1:0]   pool_free  [POOL_CHUNKS];
  int                 n_active   = 0;
  int                 cur_chunk  = 0;
  bit                 cur_live   = 1'b0;
  logic [BSIZE_W-1:0] set_block_size = BSIZE_RST;
  logic [BLK_W-1:0]   set_blocks     = NBLOCKS_RST;

  response_t   responses_due [$];  // one entry per accepted request word, oldest first
  held_block_t blocks_held [$];    // blocks granted and not yet given back
  int          failures      = 0;
  int          no_space_seen = 0;
  int          idle_pct      = 23;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A zero setting means one block per chunk.
  function automatic int blocks_in_use();
    return (set_blocks == '0) ? 1 : int'(set_blocks);
  endfunction

  // Clamp the block size to 4096 bytes.
  function automatic int bytes_per_block();
    return (set_block_size > BSIZE_MAX) ? int'(BSIZE_MAX) : int'(set_block_size);
  endfunction

  function automatic bit pool_would_grow();
    for (int c = 0; c < n_active; c++)
      if (pool_free[c] != '0) return 1'b0;
    return 1'b1;
  endfunction

  // Apply one request to the pool copy and return the response word it must give.
  function automatic response_t serve_request(logic req, logic [3:0] ci, logic [BLK_W-1:0] bi);
    response_t r;
    int        c;
    int        b;
    int        n;
    bit        found;
    r.status = ST_GRANT;
    r.chunk  = '0;
    r.block  = '0;
    r.offset = '0;
    if (req == REQ_RELEASE) begin
      // Reject a chunk not yet active or a block beyond the present chunk size.
      if (ci >= n_active || bi >= blocks_in_use()) begin
        r.status = ST_REJECT;
        return r;
      end
      // Push the block onto its chunk's free list.
      pool_links[ci][bi] = pool_heads[ci];
      pool_heads[ci]     = bi;
      pool_free[ci]      = pool_free[ci] + 1'b1;
      r.status = ST_RELEASED;
      return r;
    end
    if (!cur_live || pool_free[cur_chunk] == '0) begin
      // Scan the active chunks in index order for the first with space.
      found = 1'b0;
      for (c = 0; c < n_active && !found; c++) begin
        if (pool_free[c] != '0) begin
          cur_chunk = c;
          cur_live  = 1'b1;
          found     = 1'b1;
        end
      end
      if (!found) begin
        if (n_active >= POOL_CHUNKS) begin
          r.status = ST_NO_SPACE;
          return r;
        end
        // Activate the next chunk: block k links to k+1, the last one included.
        n = blocks_in_use();
        for (b = 0; b < n; b++) pool_links[n_active][b] = BLK_W'(b + 1);
        pool_heads[n_active] = '0;
        pool_free[n_active]  = BLK_W'(n);
        cur_chunk = n_active;
        cur_live  = 1'b1;
        n_active++;
      end
    end
    // Pop the head of the current chunk.
    b = int'(pool_heads[cur_chunk]);
    pool_heads[cur_chunk] = pool_links[cur_chunk][b];
    pool_free[cur_chunk]  = pool_free[cur_chunk] - 1'b1;
    r.chunk  = CHUNK_OUT_W'(cur_chunk);
    r.block  = BLK_W'(b);
    r.offset = OFFSET_W'(b * bytes_per_block());
    return r;
  endfunction

  // Present one request word from a falling edge on, hold it until accepted, then
  // predict its response. Valid stays high on return: the next call or settle_pool
  // decides at the next falling edge whether to drop it or move on to a new word.
  task automatic send_request(logic req, logic [3:0] ci, logic [BLK_W-1:0] bi);
    response_t   r;
    held_block_t h;
    int          k;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_chunk_index <= ci;
    in_block_index <= bi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = serve_request(req, ci, bi);
    responses_due = {responses_due, r};
    // Track ownership so that only blocks actually held are ever given back.
    case (r.status)
      ST_GRANT: begin
        h.chunk = r.chunk;
        h.block = r.block;
        blocks_held = {blocks_held, h};
      end
      ST_RELEASED: begin
        for (k = 0; k < blocks_held.size(); k++) begin
          if (blocks_held[k].chunk == ci && blocks_held[k].block == bi) begin
            blocks_held.delete(k);
            break;
          end
        end
      end
      ST_NO_SPACE: no_space_seen++;
      default: ;
    endcase
  endtask

  // Drop valid and wait until every response word has come back.
  task automatic settle_pool();
    @(negedge clk);
    in_valid <= 1'b0;
    while (responses_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_BLOCK_SIZE) set_block_size = value;
    else set_blocks = value[BLK_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers change only while the block is idle.
  task automatic configure(logic [CFG_DATA_W-1:0] bsize, logic [CFG_DATA_W-1:0] nblocks);
    settle_pool();
    write_register(REG_BLOCK_SIZE, bsize);
    write_register(REG_BLOCKS_PER_CHUNK, nblocks);
  endtask

  // Mixed traffic: allocations, releases of held blocks and out-of-range releases.
  // Unless allow_last is set, hold back the allocation that would activate the final
  // chunk, so it can be made a large one at the end.
  task automatic run_traffic(int count, int alloc_pct, bit allow_last);
    int          i;
    int          pick;
    held_block_t h;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct &&
          (allow_last || n_active < POOL_CHUNKS - 1 || !pool_would_grow())) begin
        // chunk and block fields are don't-care on allocate: randomize them
        send_request(REQ_ALLOC, 4'($urandom), 8'($urandom));
      end else if (pick < alloc_pct + 8 || blocks_held.size() == 0) begin
        if (n_active < POOL_CHUNKS && $urandom_range(1) == 1)
          send_request(REQ_RELEASE, 4'($urandom_range(15, n_active)), 8'($urandom));
        else
          send_request(REQ_RELEASE, 4'($urandom), 8'($urandom_range(255, blocks_in_use())));
      end else begin
        h = blocks_held[$urandom_range(blocks_held.size() - 1)];
        send_request(REQ_RELEASE, h.chunk, h.block);
      end
    end
  endtask

  // Releases before any chunk exists are all rejected.
  task automatic test_empty_pool_release();
    send_request(REQ_RELEASE, 4'd0, 8'd0);
    send_request(REQ_RELEASE, 4'd15, 8'd255);
  endtask

  // Zero blocks per chunk acts as one: an allocation with no free block activates a
  // new chunk, and a released block is found again by the scan.
  task automatic test_single_block_chunks();
    configure(13'd1, 13'd0);
    send_request(REQ_ALLOC, 4'd0, 8'd0);
    send_request(REQ_ALLOC, 4'd15, 8'd255);
    send_request(REQ_RELEASE, 4'd0, 8'd0);
    send_request(REQ_ALLOC, 4'd0, 8'd0);
    send_request(REQ_RELEASE, 4'd0, 8'd1);
    send_request(REQ_RELEASE, 4'd2, 8'd0);
  endtask

  // Block size above 4096 clamps; the released block comes back first.
  task automatic test_oversized_block_size();
    configure(13'h1FFF, 13'd3);
    repeat (3) send_request(REQ_ALLOC, 4'd0, 8'd0);
    send_request(REQ_RELEASE, 4'd2, 8'd1);
    send_request(REQ_ALLOC, 4'd0, 8'd0);
  endtask

  // Block size zero gives zero offsets.
  task automatic test_zero_block_size();
    configure(13'd0, 13'd3);
    repeat (2) send_request(REQ_ALLOC, 4'd0, 8'd0);
  endtask

  // Random phases, each with fresh settings; one longer phase runs without any idling.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] bsize;
    logic [CFG_DATA_W-1:0] nblocks;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(7))
        0: bsize = 13'd0;
        1: bsize = 13'd1;
        2: bsize = BSIZE_MAX;
        3: bsize = 13'h1FFF;
        default: bsize = CFG_DATA_W'($urandom_range(4096, 1));
      endcase
      nblocks  = (phase == 5) ? CFG_DATA_W'($urandom_range(40, 10))
                              : CFG_DATA_W'($urandom_range(9));
      idle_pct = (phase == 3) ? 0 : 23;
      configure(bsize, nblocks);
      run_traffic((phase == 3) ? 30 : 10, phase[0] ? 45 : 70, 1'b0);
    end
    idle_pct = 23;
  endtask

  // Use up every chunk but the last with one-block chunks, then activate the last
  // chunk with 255 blocks of 4096 bytes, fill the pool until it answers no space,
  // then churn across all chunks.
  task automatic test_pool_full();
    int guard;
    configure(BSIZE_MAX, 13'd1);
    while (n_active < POOL_CHUNKS - 1 || !pool_would_grow())
      send_request(REQ_ALLOC, 4'($urandom), 8'($urandom));
    configure(BSIZE_MAX, 13'd255);
    no_space_seen = 0;
    guard = 0;
    while (no_space_seen < 3 && guard < 2000) begin
      run_traffic(1, 92, 1'b1);
      guard++;
    end
    run_traffic(20, 50, 1'b1);
  endtask

  task automatic check_field(string what, logic [OFFSET_W-1:0] want, logic [OFFSET_W-1:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= REPORT_MAX)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Result channel: stall at random, sample at the rising edge, compare every
  // accepted word with the oldest prediction.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && out_ready) begin
      if (responses_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%0t: response word with none expected: expected nothing, actual status %0d",
                   $time, out_status);
      end else begin
        want = responses_due.pop_front();
        check_field("status", want.status, out_status);
        check_field("chunk_index_out", want.chunk, out_chunk_index_out);
        check_field("block_index_out", want.block, out_block_index_out);
        check_field("byte_offset", want.offset, out_byte_offset);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("fixed_block_pool_allocator_test failed");
    $finish;
  end

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_pool_release();
    test_single_block_chunks();
    test_oversized_block_size();
    test_zero_block_size();
    test_random_traffic();
    test_pool_full();

    // Drain outstanding words, then give the block time to show any stray word.
    settle_pool();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("fixed_block_pool_allocator_test passed");
    else
      $display("fixed_block_pool_allocator_test failed");
    $finish;
  end

endmodule
